### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the salted hash core RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge out of reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### sv/sfmh_pkg.sv
// ----------------------------------------------------------------------------
// sfmh_pkg
// Types, constants and helpers for the salted FNV-1a / fmix64 hash core.
// ----------------------------------------------------------------------------
package sfmh_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned HALF_W   = HASH_W / 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROUNDS_W = 12;

  localparam logic [HASH_W-1:0] SEED_BASIS = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] STEP_MUL   = 64'h00000100000001b3;
  localparam logic [HASH_W-1:0] FMIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] FMIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned       FMIX_SHIFT = 33;

  localparam logic [ROUNDS_W-1:0] MIX_ROUNDS_RESET = 12'd1024;

  // Sequencer states of the core
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WAIT_FNV,
    S_WAIT_A,
    S_WAIT_B
  } sfmh_state_e;

  // Partial-product steps of the shared multiplier
  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL,
    MS_ACC
  } mul_step_e;

  // Request into the shared multiplier
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  // Response from the shared multiplier
  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] result;
  } mul_rsp_t;

  // Xor-shift step of the fmix64 finalizer
  function automatic logic [HASH_W-1:0] xorshift(input logic [HASH_W-1:0] h);
    xorshift = h ^ (h >> FMIX_SHIFT);
  endfunction

endpackage

### sv/sfmh_mul64.sv
// ----------------------------------------------------------------------------
// sfmh_mul64
// Iterative 64x64 multiplier returning the low 64 bits of the product.
// One 32x32 multiplier forms three partial products in turn; the
// cross terms only touch the upper half. The result is flagged by a
// one-cycle done pulse and holds until the next start.
// ----------------------------------------------------------------------------
module sfmh_mul64 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfmh_pkg::mul_req_t req_i,
  output sfmh_pkg::mul_rsp_t rsp_o
);
  import sfmh_pkg::*;

  logic [HASH_W-1:0] a_q, a_d, b_q, b_d;
  logic [HASH_W-1:0] res_q, res_d;
  logic [HASH_W-1:0] prod_q, prod_d;
  mul_step_e         step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [HALF_W-1:0] op_a, op_b;

  // Select the operand halves for the current step
  always_comb begin
    unique case (step_q)
      MS_LH: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[HASH_W-1:HALF_W];
      end
      MS_HL: begin
        op_a = a_q[HASH_W-1:HALF_W];
        op_b = b_q[HALF_W-1:0];
      end
      default: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[HALF_W-1:0];
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  // Advance the step counter and fold the previous partial product
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    res_d  = res_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      step_d = MS_LL;
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (step_q)
        MS_LL: begin
          step_d = MS_LH;
        end
        MS_LH: begin
          res_d  = prod_q;
          step_d = MS_HL;
        end
        MS_HL: begin
          res_d[HASH_W-1:HALF_W] = res_q[HASH_W-1:HALF_W] + prod_q[HALF_W-1:0];
          step_d = MS_ACC;
        end
        MS_ACC: begin
          res_d[HASH_W-1:HALF_W] = res_q[HASH_W-1:HALF_W] + prod_q[HALF_W-1:0];
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MS_LL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand and product registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    prod_q <= prod_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

### sv/salted_fnv1a_iterated_mix_hash_core.sv
// ----------------------------------------------------------------------------
// salted_fnv1a_iterated_mix_hash_core
// Salted FNV-1a-64 password hash with iterated fmix64 finalization.
//
// A password streams in one byte per input transaction (valid/ready). The
// first transaction seeds the accumulator with the offset basis XOR salt_i
// and multiplies by the FNV prime; each transaction with byte_valid_i set
// folds pw_byte_i in and multiplies again. A transaction with last_i set
// runs mix_rounds fmix64 rounds and posts one hash_o transaction.
// All 64-bit multiplies go through one iterative unit that forms three
// 32x32 partial products. in_ready_o is low while a transaction runs the
// FNV multiplies it needs (0 to 2) and, if last_i is set, mix_rounds
// fmix64 rounds, with mix_rounds ranging from 0 to 4095.
// The result sits in an output register: if out_ready_i is low the next
// non-final transactions are still taken, and a final one waits for the
// register to drain before it posts. Reset drops any password in progress
// and sets mix_rounds to 1024. cfg_we_i writes it; the user must write it
// only while the core is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salted_fnv1a_iterated_mix_hash_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfmh_pkg::ROUNDS_W-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sfmh_pkg::HASH_W-1:0]        salt_i,
  input  logic [sfmh_pkg::BYTE_W-1:0]        pw_byte_i,
  input  logic                               byte_valid_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sfmh_pkg::HASH_W-1:0]        hash_o
);
  import sfmh_pkg::*;

  sfmh_state_e         state_q, state_d;
  logic [HASH_W-1:0]   acc_q, acc_d;
  logic [HASH_W-1:0]   hash_q, hash_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [ROUNDS_W-1:0] rounds_q, rounds_d;
  logic [ROUNDS_W-1:0] mix_rounds_q, mix_rounds_d;
  logic                in_pw_q, in_pw_d;
  logic                seed_pend_q, seed_pend_d;
  logic                byte_pend_q, byte_pend_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic                in_fire;
  logic                out_free;
  mul_req_t            mul_req;
  mul_rsp_t            mul_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  // Shared 64-bit multiplier
  sfmh_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Latch the round count register
  assign mix_rounds_d = cfg_we_i ? cfg_wdata_i : mix_rounds_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (seed_pend_q || byte_pend_q) begin
          state_d = S_WAIT_FNV;
        end else if (!last_q) begin
          state_d = S_IDLE;
        end else if (rounds_q != '0) begin
          state_d = S_WAIT_A;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WAIT_FNV: begin
        if (mul_rsp.done) state_d = S_DISPATCH;
      end
      S_WAIT_A: begin
        if (mul_rsp.done) state_d = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (mul_rsp.done) state_d = S_DISPATCH;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    acc_d       = acc_q;
    hash_d      = hash_q;
    byte_d      = byte_q;
    rounds_d    = rounds_q;
    in_pw_d     = in_pw_q;
    seed_pend_d = seed_pend_q;
    byte_pend_d = byte_pend_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          byte_d      = pw_byte_i;
          byte_pend_d = byte_valid_i;
          last_d      = last_i;
          seed_pend_d = !in_pw_q;
          rounds_d    = mix_rounds_q;
          in_pw_d     = 1'b1;
          if (!in_pw_q) acc_d = SEED_BASIS ^ salt_i;
        end
      end
      S_DISPATCH: begin
        if (seed_pend_q) begin
          mul_req.start = 1'b1;
          mul_req.a     = acc_q;
          mul_req.b     = STEP_MUL;
          seed_pend_d   = 1'b0;
        end else if (byte_pend_q) begin
          mul_req.start = 1'b1;
          mul_req.a     = acc_q ^ {{(HASH_W-BYTE_W){1'b0}}, byte_q};
          mul_req.b     = STEP_MUL;
          byte_pend_d   = 1'b0;
        end else if (last_q && rounds_q != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = xorshift(acc_q);
          mul_req.b     = FMIX_MUL_A;
        end else if (last_q && out_free) begin
          hash_d      = acc_q;
          out_valid_d = 1'b1;
          in_pw_d     = 1'b0;
        end
      end
      S_WAIT_FNV: begin
        if (mul_rsp.done) acc_d = mul_rsp.result;
      end
      S_WAIT_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xorshift(mul_rsp.result);
          mul_req.b     = FMIX_MUL_B;
        end
      end
      S_WAIT_B: begin
        if (mul_rsp.done) begin
          acc_d    = xorshift(mul_rsp.result);
          rounds_d = rounds_q - 1'b1;
        end
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rounds_q     <= '0;
      mix_rounds_q <= MIX_ROUNDS_RESET;
      in_pw_q      <= 1'b0;
      seed_pend_q  <= 1'b0;
      byte_pend_q  <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rounds_q     <= rounds_d;
      mix_rounds_q <= mix_rounds_d;
      in_pw_q      <= in_pw_d;
      seed_pend_q  <= seed_pend_d;
      byte_pend_q  <= byte_pend_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    hash_q <= hash_d;
    byte_q <= byte_d;
  end

  // Every multiply start is followed by its done pulse
  `ASSERT_AT(a_mul_latency, mul_req.start |-> ##5 mul_rsp.done, "multiply did not complete")
  // Results only arrive while the sequencer waits for them
  `ASSERT_AT(a_done_in_wait, mul_rsp.done |-> (state_q == S_WAIT_FNV ||
    state_q == S_WAIT_A || state_q == S_WAIT_B), "multiply result arrived unexpectedly")
  // A finalizer round never starts with the round count exhausted
  `ASSERT_AT(a_round_count, (state_q == S_WAIT_A) |-> (rounds_q != '0), "round underflow")
  // Posting a hash ends the password
  `ASSERT_AT(a_post_ends_pw, $rose(out_valid_q) |-> !in_pw_q, "password still open after hash")

endmodule

### tb/tb_salted_fnv1a_iterated_mix_hash_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_salted_fnv1a_iterated_mix_hash_core
// Self-checking bench for the salted FNV-1a / fmix64 password hash core.
//
// A short table of hand-picked passwords runs first: empty passwords, field
// extremes, invalid bytes, ignored salts, zero and maximum round counts and a
// round-count change in the middle of a password. A long random stream of
// mostly well-formed passwords follows, split into phases with fresh round
// counts. Every hash is checked against an in-bench model of the core or a
// hand-computed value. Both handshake sides idle at random and the output is
// held off once for a long stretch so the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_salted_fnv1a_iterated_mix_hash_core;

  localparam int unsigned HW = sfmh_pkg::HASH_W;
  localparam int unsigned BW = sfmh_pkg::BYTE_W;
  localparam int unsigned RW = sfmh_pkg::ROUNDS_W;

  // Hash constants for the in-bench model
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MULT  = 64'h00000100000001b3;
  localparam logic [63:0] FIN_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FIN_SHIFT = 33;
  localparam logic [RW-1:0] ROUNDS_AFTER_RESET = 12'd1024;

  localparam int unsigned ITEMS_TOTAL  = 1150;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned PRINT_CAP    = 20;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [HW-1:0] salt;
    logic [BW-1:0] pw_byte;
    logic          byte_valid;
    logic          last;
    logic          typed;
    logic [HW-1:0] typed_hash;
    logic [RW-1:0] rounds;
  } stim_row_t;

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          cfg_we_i     = 1'b0;
  logic [RW-1:0] cfg_wdata_i  = '0;
  logic          in_valid_i   = 1'b0;
  logic          in_ready_o;
  logic [HW-1:0] salt_i       = '0;
  logic [BW-1:0] pw_byte_i    = '0;
  logic          byte_valid_i = 1'b0;
  logic          last_i       = 1'b0;
  logic          out_valid_o;
  logic          out_ready_i  = 1'b0;
  logic [HW-1:0] hash_o;

  // Model state
  logic [HW-1:0] hash_acc     = '0;
  logic          pw_open      = 1'b0;
  logic [RW-1:0] mix_rounds_q = ROUNDS_AFTER_RESET;
  logic [HW-1:0] pending_hashes[$];

  // Receiver pacing and pressure
  logic        rx_hold  = 1'b0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm  = 0;
  int unsigned tx_calm  = 0;
  logic        stress_armed = 1'b0;

  // Bookkeeping
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned hashes_checked = 0;
  int unsigned cfg_writes     = 0;
  int unsigned mismatches     = 0;
  int unsigned hold_stalls    = 0;

  stim_row_t directed_rows[$];

  salted_fnv1a_iterated_mix_hash_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .salt_i       (salt_i),
    .pw_byte_i    (pw_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_o       (hash_o)
  );

  // Toggle the clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One fmix64 finalizer round
  function automatic logic [HW-1:0] fmix64_round(input logic [HW-1:0] h);
    logic [HW-1:0] x;
    x = h ^ (h >> FIN_SHIFT);
    x = x * FIN_MUL_A;
    x = x ^ (x >> FIN_SHIFT);
    x = x * FIN_MUL_B;
    x = x ^ (x >> FIN_SHIFT);
    return x;
  endfunction

  // Advance the model by one accepted transaction; queue a hash on last
  task automatic absorb_item(input logic [HW-1:0] salt, input logic [BW-1:0] b,
                             input logic bv, input logic lst,
                             input logic typed, input logic [HW-1:0] typed_hash);
    if (!pw_open) begin
      hash_acc = (FNV_BASIS ^ salt) * FNV_MULT;
      pw_open  = 1'b1;
    end
    if (bv) begin
      hash_acc = (hash_acc ^ {{(HW-BW){1'b0}}, b}) * FNV_MULT;
    end
    if (lst) begin
      for (int unsigned r = 0; r < mix_rounds_q; r++) begin
        hash_acc = fmix64_round(hash_acc);
      end
      pw_open = 1'b0;
      pending_hashes.push_back(typed ? typed_hash : hash_acc);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [HW-1:0] got,
                                 input logic [HW-1:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Offer one input transaction after a random gap; hold until accepted
  task automatic send_item(input logic [HW-1:0] salt, input logic [BW-1:0] b,
                           input logic bv, input logic lst,
                           input logic typed, input logic [HW-1:0] typed_hash);
    int unsigned gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    salt_i       <= salt;
    pw_byte_i    <= b;
    byte_valid_i <= bv;
    last_i       <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_item(salt, b, bv, lst, typed, typed_hash);
    items_sent++;
  endtask

  // Wait for the core to go idle, then write the round count
  task automatic write_rounds(input logic [RW-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    mix_rounds_q = v;
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  function automatic stim_row_t item_row(input logic [HW-1:0] salt,
                                         input logic [BW-1:0] b, input logic bv,
                                         input logic lst, input logic typed,
                                         input logic [HW-1:0] typed_hash);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.salt = salt;
    r.pw_byte = b;
    r.byte_valid = bv;
    r.last = lst;
    r.typed = typed;
    r.typed_hash = typed_hash;
    r.rounds = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [RW-1:0] v);
    stim_row_t r;
    r = item_row('0, '0, 1'b0, 1'b0, 1'b0, '0);
    r.kind = ROW_CFG;
    r.rounds = v;
    return r;
  endfunction

  function automatic logic [HW-1:0] pick_salt();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return FNV_BASIS;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Check each output transaction against the oldest queued hash
  always @(posedge clk_i) begin : hash_check
    logic [HW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("unexpected hash", hash_o, '0);
      end else begin
        want = pending_hashes.pop_front();
        if (hash_o !== want) report_mismatch("hash", hash_o, want);
        hashes_checked++;
      end
    end
    if (rx_hold && in_valid_i && !in_ready_o) hold_stalls++;
  end

  // Pace the output side: random stall after each transaction, plus hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rx_calm > 0) begin
        rx_stall = 0;
        rx_calm--;
      end else begin
        rx_stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(10, 40);
      end
    end else if (rx_stall > 0) begin
      rx_stall--;
    end
    out_ready_i <= (rx_stall == 0) && !rx_hold;
  end

  // Hold off the output once, long enough to back up the input
  initial begin
    wait (stress_armed);
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d hashes outstanding", cycle_count,
               pending_hashes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase_left;
    int unsigned pw_len;
    logic        broken;

    // Empty password seeded to zero stays zero through any number of rounds
    directed_rows.push_back(item_row(FNV_BASIS, 8'h00, 1'b0, 1'b1, 1'b1, '0));
    // Extremes, ignored salt, invalid byte mid-password
    directed_rows.push_back(item_row('1, 8'hff, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row('0, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row(64'h0123456789abcdef, 8'h5a, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row(64'hfedcba9876543210, 8'h80, 1'b1, 1'b1, 1'b0, '0));
    // Zero rounds: unmixed accumulator, all-ones seed times the prime
    directed_rows.push_back(cfg_row(12'd0));
    directed_rows.push_back(item_row(~FNV_BASIS, 8'h00, 1'b0, 1'b1, 1'b1,
                                     64'hfffffeff_fffffe4d));
    directed_rows.push_back(item_row('1, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row('0, 8'h01, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row('0, 8'hfe, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row('0, 8'h00, 1'b1, 1'b1, 1'b0, '0));
    // Change the round count in the middle of a password
    directed_rows.push_back(item_row(64'h5555555555555555, 8'h7f, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(cfg_row(12'd4095));
    directed_rows.push_back(item_row(64'haaaaaaaaaaaaaaaa, 8'haa, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(FNV_BASIS, 8'h55, 1'b0, 1'b1, 1'b1, '0));
    directed_rows.push_back(cfg_row(12'd1));
    directed_rows.push_back(item_row('1, 8'hff, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(FNV_BASIS, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row('0, 8'hff, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(cfg_row(12'haaa));
    directed_rows.push_back(item_row(64'h0f0f0f0f0f0f0f0f, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(cfg_row(12'h555));
    directed_rows.push_back(item_row(64'hf0f0f0f0f0f0f0f0, 8'h33, 1'b1, 1'b1, 1'b0, '0));

    // Hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_rounds(directed_rows[i].rounds);
      end else begin
        send_item(directed_rows[i].salt, directed_rows[i].pw_byte,
                  directed_rows[i].byte_valid, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].typed_hash);
      end
    end

    // Random passwords in phases, each with its own round count
    stress_armed = 1'b1;
    phase_left = 0;
    while (items_sent < ITEMS_TOTAL) begin
      if (phase_left == 0) begin
        write_rounds(RW'($urandom_range(0, 40)));
        phase_left = $urandom_range(120, 200);
      end
      if ($urandom_range(0, 11) == 0) begin
        // Noise: one fully random transaction
        send_item(pick_salt(), BW'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        phase_left = (phase_left > 0) ? phase_left - 1 : 0;
      end else begin
        pw_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                              : $urandom_range(1, 14);
        broken = ($urandom_range(0, 14) == 0);
        if (pw_len == 0) begin
          send_item(pick_salt(), BW'($urandom), 1'b0, 1'b1, 1'b0, '0);
          phase_left = (phase_left > 0) ? phase_left - 1 : 0;
        end else begin
          for (int unsigned k = 0; k < pw_len; k++) begin
            send_item(pick_salt(), BW'($urandom), ($urandom_range(0, 9) != 0),
                      (k == pw_len - 1) && !broken, 1'b0, '0);
            phase_left = (phase_left > 0) ? phase_left - 1 : 0;
          end
        end
      end
    end

    // Close any password left open, then drain
    if (pw_open) send_item(pick_salt(), BW'($urandom), 1'b1, 1'b1, 1'b0, '0);
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Run covered %0d input transactions, %0d hashes checked, %0d round-count writes",
             items_sent, hashes_checked, cfg_writes);
    $display("Output hold-off stalled the input for %0d cycles; %0d mismatches",
             hold_stalls, mismatches);
    if (mismatches == 0 && pending_hashes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sfmh_pkg.sv
sv/sfmh_mul64.sv
sv/salted_fnv1a_iterated_mix_hash_core.sv
tb/tb_salted_fnv1a_iterated_mix_hash_core.sv
